// ===== rtl/core/orbit_frame_from_state_core_defines.svh =====
// Shared assertion macros for the orbit frame core.
`ifndef ORBIT_FRAME_FROM_STATE_CORE_DEFINES_SVH
`define ORBIT_FRAME_FROM_STATE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OFS_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define OFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ofs_pkg.sv =====
package ofs_pkg;

    localparam int FRACTION_BITS_DEF = 30;
    localparam int IN_W              = 32;
    localparam int AXIS_W            = 32;
    localparam int CROSS_W           = 64;
    localparam int P_W               = 32;
    localparam int MAG_W             = 31;
    localparam int SQRT_STEPS        = 32;
    localparam int NORM_FIXED_LAT    = 39;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                    deg;
        logic [2:0]              c_neg;
        logic [2:0][CROSS_W-1:0] c_mag;
        logic [2:0]              p_neg;
        logic [2:0][P_W-1:0]     p_mag;
    } ofs_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ofs_qctl_t;

    function automatic int norm_latency(input int frac);
        return NORM_FIXED_LAT + frac;
    endfunction

endpackage

// ===== rtl/core/ofs_front.sv =====
`include "orbit_frame_from_state_core_defines.svh"

module ofs_front
    import ofs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [IN_W-1:0] pos_x,
    input  logic signed [IN_W-1:0] pos_y,
    input  logic signed [IN_W-1:0] pos_z,
    input  logic signed [IN_W-1:0] vel_x,
    input  logic signed [IN_W-1:0] vel_y,
    input  logic signed [IN_W-1:0] vel_z,
    input  ofs_qctl_t              qctl,
    output logic                   push,
    output ofs_item_t              item
);

    logic               en;
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic signed [63:0] prod_next [6];
    logic signed [63:0] prod_reg [6];
    logic [2:0]         pneg_next;
    logic [2:0][P_W-1:0] pmag_next;
    logic [2:0]         pneg_reg;
    logic [2:0][P_W-1:0] pmag_reg;
    logic               pzero_reg;
    ofs_item_t          item_next;
    ofs_item_t          item_reg;
    logic signed [64:0] diff [3];
    logic signed [IN_W-1:0] pos [3];

    assign en       = !(s2_valid_reg && qctl.full);
    assign in_stall = !en;
    assign push     = s2_valid_reg && !qctl.full;
    assign item     = item_reg;

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;

    assign prod_next[0] = vel_y * pos_z;
    assign prod_next[1] = vel_z * pos_y;
    assign prod_next[2] = vel_z * pos_x;
    assign prod_next[3] = vel_x * pos_z;
    assign prod_next[4] = vel_x * pos_y;
    assign prod_next[5] = vel_y * pos_x;

    // z axis points along -p: negative component where p is positive
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pneg_next[i] = !pos[i][IN_W-1];
            pmag_next[i] = pos[i][IN_W-1] ? P_W'(-pos[i]) : P_W'(pos[i]);
        end
    end

    always_comb
    begin
        item_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {prod_reg[2*i][63], prod_reg[2*i]}
                    - {prod_reg[2*i+1][63], prod_reg[2*i+1]};
            item_next.c_neg[i] = diff[i][64];
            item_next.c_mag[i] = diff[i][64] ? CROSS_W'(-diff[i]) : diff[i][63:0];
        end
        item_next.p_neg = pneg_reg;
        item_next.p_mag = pmag_reg;
        item_next.deg   = pzero_reg || (item_next.c_mag == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            pneg_reg  <= pneg_next;
            pmag_reg  <= pmag_next;
            pzero_reg <= (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
            item_reg  <= item_next;
        end
    end

    `OFS_ASSERT_NEXT(a_front_hold, s2_valid_reg && qctl.full, s2_valid_reg, "front dropped a request held by a full queue")

endmodule

// ===== rtl/core/ofs_queue.sv =====
`include "orbit_frame_from_state_core_defines.svh"

module ofs_queue
    import ofs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ofs_item_t push_item,
    input  logic      pop,
    output ofs_item_t head,
    output ofs_qctl_t qctl
);

    ofs_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign qctl.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qctl.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `OFS_ASSERT_HOLDS(a_queue_no_overflow, count_reg == QCNT_W'(QUEUE_DEPTH), !push, "push into full queue")
    `OFS_ASSERT_HOLDS(a_queue_no_underflow, count_reg == '0, !pop, "pop from empty queue")

endmodule

// ===== rtl/core/ofs_norm.sv =====
module ofs_norm
    import ofs_pkg::*;
#(
    parameter int W             = CROSS_W,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [2:0][W-1:0]       mag,
    input  logic [2:0]              neg,
    output logic [2:0][AXIS_W-1:0]  unit
);

    localparam int LW     = $clog2(W + 1);
    localparam int QW     = FRACTION_BITS + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W  = ROOT_W + 2;
    localparam int N_W    = ROOT_W + 1;
    localparam int DIV_W  = 64;

    logic [W-1:0]              any_bits;
    logic [LW-1:0]             len_next;
    logic [2:0][W-1:0]         mag1_reg;
    logic [LW-1:0]             len1_reg;
    logic [2:0]                neg1_reg;
    logic [2:0][MAG_W-1:0]     m2_next;
    logic [2:0][MAG_W-1:0]     m2_reg;
    logic [2:0]                neg2_reg;
    logic [2:0][SQ_W-1:0]      sq3_reg;
    logic [2:0][MAG_W-1:0]     m3_reg;
    logic [2:0]                neg3_reg;
    logic [SUM_W-1:0]          sum4_reg;
    logic [2:0][MAG_W-1:0]     m4_reg;
    logic [2:0]                neg4_reg;

    logic [REM_W-1:0]          rem_reg  [1:SQRT_STEPS];
    logic [ROOT_W-1:0]         root_reg [1:SQRT_STEPS];
    logic [SUM_W-1:0]          rad_reg  [1:SQRT_STEPS];
    logic [2:0][MAG_W-1:0]     ms_reg   [1:SQRT_STEPS];
    logic [2:0]                ns_reg   [1:SQRT_STEPS];

    logic [N_W-1:0]            nr_reg;
    logic [2:0][MAG_W-1:0]     mr_reg;
    logic [2:0]                negr_reg;

    logic [2:0][DIV_W-1:0]     dd_reg   [1:QW-1];
    logic [N_W-1:0]            nd_reg   [1:QW-1];
    logic [2:0][QW-1:0]        qq_reg   [1:QW];
    logic [2:0]                negd_reg [1:QW];

    logic [2:0][AXIS_W-1:0]    unit_reg;

    always_comb
    begin
        any_bits = mag[0] | mag[1] | mag[2];
        len_next = '0;
        for (int i = 0; i < W; i++)
        begin
            if (any_bits[i])
            begin
                len_next = LW'(i + 1);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (len1_reg > LW'(MAG_W))
            begin
                m2_next[i] = MAG_W'(mag1_reg[i] >> (len1_reg - LW'(MAG_W)));
            end
            else
            begin
                m2_next[i] = mag1_reg[i][MAG_W-1:0] << (LW'(MAG_W) - len1_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg <= mag;
            len1_reg <= len_next;
            neg1_reg <= neg;
            m2_reg   <= m2_next;
            neg2_reg <= neg1_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq3_reg[i] <= SQ_W'(m2_reg[i]) * SQ_W'(m2_reg[i]);
            end
            m3_reg   <= m2_reg;
            neg3_reg <= neg2_reg;
            sum4_reg <= SUM_W'(sq3_reg[0]) + SUM_W'(sq3_reg[1]) + SUM_W'(sq3_reg[2]);
            m4_reg   <= m3_reg;
            neg4_reg <= neg3_reg;
        end
    end

    genvar k;
    for (k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [REM_W-1:0]      r_in;
        logic [ROOT_W-1:0]     q_in;
        logic [SUM_W-1:0]      s_in;
        logic [2:0][MAG_W-1:0] m_in;
        logic [2:0]            n_in;
        logic [REM_W+1:0]      trial;
        logic [REM_W+1:0]      sub;
        logic                  ge;

        if (k == 0)
        begin : g_first
            assign r_in = '0;
            assign q_in = '0;
            assign s_in = sum4_reg;
            assign m_in = m4_reg;
            assign n_in = neg4_reg;
        end
        else
        begin : g_mid
            assign r_in = rem_reg[k];
            assign q_in = root_reg[k];
            assign s_in = rad_reg[k];
            assign m_in = ms_reg[k];
            assign n_in = ns_reg[k];
        end

        assign trial = {r_in, s_in[SUM_W-1 -: 2]};
        assign sub   = {2'b00, q_in, 2'b01};
        assign ge    = (trial >= sub);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? REM_W'(trial - sub) : REM_W'(trial);
                root_reg[k+1] <= {q_in[ROOT_W-2:0], ge};
                rad_reg[k+1]  <= {s_in[SUM_W-3:0], 2'b00};
                ms_reg[k+1]   <= m_in;
                ns_reg[k+1]   <= n_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nr_reg   <= N_W'(root_reg[SQRT_STEPS])
                      + N_W'(rem_reg[SQRT_STEPS] > REM_W'(root_reg[SQRT_STEPS]));
            mr_reg   <= ms_reg[SQRT_STEPS];
            negr_reg <= ns_reg[SQRT_STEPS];
        end
    end

    genvar j;
    for (j = 0; j < QW; j++)
    begin : g_div
        localparam int SH = QW - 1 - j;
        logic [2:0][DIV_W-1:0] d_in;
        logic [2:0][QW-1:0]    q_in;
        logic [N_W-1:0]        n_in;
        logic [2:0]            s_in;
        logic [DIV_W-1:0]      trial;
        logic [2:0][DIV_W-1:0] d_next;
        logic [2:0][QW-1:0]    q_next;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_in[i] = (DIV_W'(mr_reg[i]) << FRACTION_BITS) + DIV_W'(nr_reg >> 1);
                end
            end
            assign q_in = '0;
            assign n_in = nr_reg;
            assign s_in = negr_reg;
        end
        else
        begin : g_mid
            assign d_in = dd_reg[j];
            assign q_in = qq_reg[j];
            assign n_in = nd_reg[j];
            assign s_in = negd_reg[j];
        end

        assign trial = DIV_W'(n_in) << SH;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (d_in[i] >= trial)
                begin
                    d_next[i] = d_in[i] - trial;
                    q_next[i] = {q_in[i][QW-2:0], 1'b1};
                end
                else
                begin
                    d_next[i] = d_in[i];
                    q_next[i] = {q_in[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qq_reg[j+1]   <= q_next;
                negd_reg[j+1] <= s_in;
            end
        end

        if (j < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dd_reg[j+1] <= d_next;
                    nd_reg[j+1] <= n_in;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                unit_reg[i] <= negd_reg[QW][i] ? -AXIS_W'(qq_reg[QW][i])
                                               : AXIS_W'(qq_reg[QW][i]);
            end
        end
    end

    assign unit = unit_reg;

endmodule

// ===== rtl/core/ofs_back.sv =====
`include "orbit_frame_from_state_core_defines.svh"

module ofs_back
    import ofs_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ofs_item_t                head,
    input  ofs_qctl_t                qctl,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [AXIS_W-1:0] xaxis_x,
    output logic signed [AXIS_W-1:0] xaxis_y,
    output logic signed [AXIS_W-1:0] xaxis_z,
    output logic signed [AXIS_W-1:0] yaxis_x,
    output logic signed [AXIS_W-1:0] yaxis_y,
    output logic signed [AXIS_W-1:0] yaxis_z,
    output logic signed [AXIS_W-1:0] zaxis_x,
    output logic signed [AXIS_W-1:0] zaxis_y,
    output logic signed [AXIS_W-1:0] zaxis_z,
    output logic                     degenerate
);

    localparam int          NL   = norm_latency(FRACTION_BITS);
    localparam logic [63:0] ONE  = 64'(1) << FRACTION_BITS;
    localparam logic [63:0] HALF = 64'(1) << (FRACTION_BITS - 1);

    logic                        en;
    logic [2:0][AXIS_W-1:0]      yu;
    logic [2:0][AXIS_W-1:0]      zu;
    logic [NL-1:0]               vld_reg;
    logic [NL-1:0]               deg_reg;
    logic signed [AXIS_W-1:0]    ys [3];
    logic signed [AXIS_W-1:0]    zs [3];
    logic signed [63:0]          pa_next [3];
    logic signed [63:0]          pb_next [3];
    logic signed [63:0]          pa_reg [3];
    logic signed [63:0]          pb_reg [3];
    logic [2:0][AXIS_W-1:0]      yx_reg;
    logic [2:0][AXIS_W-1:0]      zx_reg;
    logic                        vx_reg;
    logic                        degx_reg;
    logic signed [63:0]          d [3];
    logic [63:0]                 dmag [3];
    logic [63:0]                 q [3];
    logic [2:0][AXIS_W-1:0]      x_next;
    logic                        out_valid_reg;
    logic [2:0][AXIS_W-1:0]      xo_reg;
    logic [2:0][AXIS_W-1:0]      yo_reg;
    logic [2:0][AXIS_W-1:0]      zo_reg;
    logic                        deg_out_reg;

    assign en  = !out_valid_reg || !out_stall;
    assign pop = en && !qctl.empty;

    ofs_norm #(
        .W             (CROSS_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_norm_y (
        .clk  (clk),
        .en   (en),
        .mag  (head.c_mag),
        .neg  (head.c_neg),
        .unit (yu)
    );

    ofs_norm #(
        .W             (P_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_norm_z (
        .clk  (clk),
        .en   (en),
        .mag  (head.p_mag),
        .neg  (head.p_neg),
        .unit (zu)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ys[i] = $signed(yu[i]);
            zs[i] = $signed(zu[i]);
        end
        pa_next[0] = ys[1] * zs[2];
        pb_next[0] = ys[2] * zs[1];
        pa_next[1] = ys[2] * zs[0];
        pb_next[1] = ys[0] * zs[2];
        pa_next[2] = ys[0] * zs[1];
        pb_next[2] = ys[1] * zs[0];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i]    = pa_reg[i] - pb_reg[i];
            dmag[i] = d[i][63] ? 64'(-d[i]) : 64'(d[i]);
            q[i]    = (dmag[i] + HALF) >> FRACTION_BITS;
            if (q[i] > ONE)
            begin
                q[i] = ONE;
            end
            x_next[i] = d[i][63] ? -AXIS_W'(q[i]) : AXIS_W'(q[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            vx_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NL-2:0], pop};
            vx_reg        <= vld_reg[NL-1];
            out_valid_reg <= vx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_reg  <= {deg_reg[NL-2:0], head.deg};
            degx_reg <= deg_reg[NL-1];
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            yx_reg   <= yu;
            zx_reg   <= zu;
            deg_out_reg <= degx_reg;
            if (degx_reg)
            begin
                xo_reg <= '0;
                yo_reg <= '0;
                zo_reg <= '0;
            end
            else
            begin
                xo_reg <= x_next;
                yo_reg <= yx_reg;
                zo_reg <= zx_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign xaxis_x    = $signed(xo_reg[0]);
    assign xaxis_y    = $signed(xo_reg[1]);
    assign xaxis_z    = $signed(xo_reg[2]);
    assign yaxis_x    = $signed(yo_reg[0]);
    assign yaxis_y    = $signed(yo_reg[1]);
    assign yaxis_z    = $signed(yo_reg[2]);
    assign zaxis_x    = $signed(zo_reg[0]);
    assign zaxis_y    = $signed(zo_reg[1]);
    assign zaxis_z    = $signed(zo_reg[2]);
    assign degenerate = deg_out_reg;

    `OFS_ASSERT_HOLDS(a_deg_zero, out_valid_reg && deg_out_reg, (xo_reg == '0) && (yo_reg == '0) && (zo_reg == '0), "degenerate result with nonzero axes")
    `OFS_ASSERT_HOLDS(a_z_range, out_valid_reg && !deg_out_reg, ($signed(zo_reg[0]) <= $signed(ONE[AXIS_W-1:0])) && ($signed(zo_reg[0]) >= -$signed(ONE[AXIS_W-1:0])), "z axis out of range")

endmodule

// ===== rtl/core/orbit_frame_from_state_core.sv =====
// Orbit (local vertical, local horizontal) frame from one state vector.
// Input channel: in_valid / in_stall carry a request of position (pos_*,
// signed metres) and velocity (vel_*, signed mm/s); it is taken on a rising
// edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry the three unit axes in signed
// fixed point with FRACTION_BITS fraction bits, plus degenerate, which is set
// with all axes zero when position is zero or parallel to velocity.
// The pipelined normalizers use a 32-step square root and a FRACTION_BITS + 1
// step divider.
// Throughput: one request per cycle while out_stall is low.
// A four-entry queue sits between the cross-product front end and the
// normalizer back end. When out_stall is high with out_valid set, the back end
// holds every stage and the result; the front keeps accepting until the queue
// fills, then raises in_stall.
// Reset clears all valid flags and the queue; no request is in flight after it.
module orbit_frame_from_state_core
    import ofs_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [IN_W-1:0]   pos_x,
    input  logic signed [IN_W-1:0]   pos_y,
    input  logic signed [IN_W-1:0]   pos_z,
    input  logic signed [IN_W-1:0]   vel_x,
    input  logic signed [IN_W-1:0]   vel_y,
    input  logic signed [IN_W-1:0]   vel_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [AXIS_W-1:0] xaxis_x,
    output logic signed [AXIS_W-1:0] xaxis_y,
    output logic signed [AXIS_W-1:0] xaxis_z,
    output logic signed [AXIS_W-1:0] yaxis_x,
    output logic signed [AXIS_W-1:0] yaxis_y,
    output logic signed [AXIS_W-1:0] yaxis_z,
    output logic signed [AXIS_W-1:0] zaxis_x,
    output logic signed [AXIS_W-1:0] zaxis_y,
    output logic signed [AXIS_W-1:0] zaxis_z,
    output logic                     degenerate
);

    ofs_qctl_t qctl;
    ofs_item_t push_item;
    ofs_item_t head;
    logic      push;
    logic      pop;

    ofs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .vel_x    (vel_x),
        .vel_y    (vel_y),
        .vel_z    (vel_z),
        .qctl     (qctl),
        .push     (push),
        .item     (push_item)
    );

    ofs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qctl      (qctl)
    );

    ofs_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qctl       (qctl),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .xaxis_x    (xaxis_x),
        .xaxis_y    (xaxis_y),
        .xaxis_z    (xaxis_z),
        .yaxis_x    (yaxis_x),
        .yaxis_y    (yaxis_y),
        .yaxis_z    (yaxis_z),
        .zaxis_x    (zaxis_x),
        .zaxis_y    (zaxis_y),
        .zaxis_z    (zaxis_z),
        .degenerate (degenerate)
    );

endmodule
